FILE: hw/rtl/bfa_pkg.sv
// Shared types and constants of the best-fit block allocator.
`default_nettype none
package bfa_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_W = 16;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCKS_IN_USE = 1'b0;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_ALLOC = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [3:0]        block_index;
        logic [SIZE_W-1:0] size;
    } t_in_item;

    typedef struct packed {
        logic              allocated;
        logic [3:0]        chosen_block;
        logic [SIZE_W-1:0] remaining;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic clr;
        logic cmp;
    } t_best_ctl;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] rem;
    } t_best_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/best_fit_block_allocator_core.sv
// Top level of the best-fit block allocator: sequencer, APB register, handshakes.
`default_nettype none
// A load transfer writes one block's free size. A request transfer scans blocks
// 0 .. L-1, L = min(blocks_in_use, NUM_BLOCKS), one block per cycle through the single
// read port of the free-size RAM and one shared compare unit, then writes the reduced size
// of the chosen block back; no transfer is accepted until the request has finished.
// The result sits in an output register; a finished request waits for it to drain.
// No clearing pass after reset; a block must be loaded before a request scans it.
module best_fit_block_allocator_core #(
    parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bfa_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output bfa_pkg::t_out_item      o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    import bfa_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int XW = (AW > 4) ? AW : 4;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     r_limit;
    logic [CW-1:0]     n_limit;
    logic [SIZE_W-1:0] r_req;
    logic [SIZE_W-1:0] n_req;
    logic              r_pend;
    logic [AW-1:0]     r_pidx;
    logic              r_out_vld;
    logic              n_out_vld;
    t_out_item         r_out;
    t_out_item         n_out;
    logic [CFG_W-1:0]  r_blocks;

    logic [CW-1:0]     w_limit;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SIZE_W-1:0] ram_rdata;
    t_best_ctl         best_ctl;
    t_best_stat        best_stat;
    logic [AW-1:0]     best_idx;
    logic [XW-1:0]     w_load_idx;
    logic [XW-1:0]     w_best_idx;
    logic              w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCKS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= BLOCKS_IN_USE_RST;
        end else if (w_cfg_wr) begin
            r_blocks <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? {{(32-CFG_W){1'b0}}, r_blocks} : '0;

    assign w_limit = (32'(r_blocks) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(r_blocks);

    assign w_load_idx = XW'(i_in_data.block_index);
    assign w_best_idx = XW'(best_idx);

    assign o_in_ready = (r_state == ST_IDLE);
    assign ram_re     = (r_state == ST_SCAN);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_limit   = r_limit;
        n_req     = r_req;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = w_load_idx[AW-1:0];
        ram_wdata = i_in_data.size;
        best_ctl  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.func == FUNC_LOAD) begin
                        ram_we = (32'(i_in_data.block_index) < NUM_BLOCKS);
                    end else begin
                        n_req        = i_in_data.size;
                        n_cnt        = '0;
                        n_limit      = w_limit;
                        best_ctl.clr = 1'b1;
                        n_state      = (w_limit == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                best_ctl.cmp = r_pend;
                n_cnt        = r_cnt + CW'(1);
                if (r_cnt == r_limit - CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                best_ctl.cmp = r_pend;
                n_state      = ST_WRITE;
            end
            ST_WRITE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                    if (best_stat.found) begin
                        n_out.allocated    = 1'b1;
                        n_out.chosen_block = w_best_idx[3:0];
                        n_out.remaining    = best_stat.rem;
                        ram_we             = 1'b1;
                        ram_waddr          = best_idx;
                        ram_wdata          = best_stat.rem;
                    end else begin
                        n_out = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_pend    <= ram_re;
        end
        r_cnt   <= n_cnt;
        r_limit <= n_limit;
        r_req   <= n_req;
        r_out   <= n_out;
        r_pidx  <= r_cnt[AW-1:0];
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    bfa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    bfa_best #(
        .AW (AW)
    ) u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (best_ctl),
        .i_req   (r_req),
        .i_fs    (ram_rdata),
        .i_idx   (r_pidx),
        .o_stat  (best_stat),
        .o_idx   (best_idx)
    );

`ifndef SYNTH
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt < r_limit))
        else $error("scan counter past limit");

    a_drain_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> $past(r_state == ST_SCAN))
        else $error("drain not preceded by scan");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("ram written during scan");

    a_chosen_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.allocated) |-> (32'(r_out.chosen_block) < NUM_BLOCKS))
        else $error("chosen block out of range");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/bfa_best.sv
// Shared compare unit that tracks the best fitting block during a scan.
`default_nettype none
module bfa_best #(
    parameter int AW = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bfa_pkg::t_best_ctl           i_ctl,
    input  wire logic [bfa_pkg::SIZE_W-1:0]   i_req,
    input  wire logic [bfa_pkg::SIZE_W-1:0]   i_fs,
    input  wire logic [AW-1:0]                i_idx,
    output bfa_pkg::t_best_stat               o_stat,
    output logic      [AW-1:0]                o_idx
);
    import bfa_pkg::*;

    logic              r_found;
    logic              n_found;
    logic [SIZE_W-1:0] r_best_fs;
    logic [SIZE_W-1:0] n_best_fs;
    logic [AW-1:0]     r_best_idx;
    logic [AW-1:0]     n_best_idx;
    logic              w_better;

    assign w_better = (i_fs >= i_req) && (!r_found || (i_fs < r_best_fs));

    always_comb begin
        n_found    = r_found;
        n_best_fs  = r_best_fs;
        n_best_idx = r_best_idx;
        if (i_ctl.clr) begin
            n_found = 1'b0;
        end else if (i_ctl.cmp && w_better) begin
            n_found    = 1'b1;
            n_best_fs  = i_fs;
            n_best_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
        r_best_fs  <= n_best_fs;
        r_best_idx <= n_best_idx;
    end

    assign o_stat.found = r_found;
    assign o_stat.rem   = r_best_fs - i_req;
    assign o_idx        = r_best_idx;

endmodule
`default_nettype wire
